>>> rtl/pcrl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcrl_pkg: shared definitions for the pending command ring log
// Field widths, operation and status codes, and the slot store control word.
// ----------------------------------------------------------------------------
package pcrl_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int ID_W      = 32;
	localparam int ST_W      = 4;
	localparam int SLOT_W    = 6;
	localparam int OP_W      = 2;

	localparam logic [OP_W-1:0] OP_PLAIN_ADD  = 2'd0;
	localparam logic [OP_W-1:0] OP_CMD_ADD    = 2'd1;
	localparam logic [OP_W-1:0] OP_SET_STATUS = 2'd2;
	localparam logic [OP_W-1:0] OP_CLEAR      = 2'd3;

	localparam logic [ST_W-1:0] ST_NONE    = 4'd0;
	localparam logic [ST_W-1:0] ST_PENDING = 4'd1;

	// Strobes from the sequencer to the two slot stores.
	typedef struct packed {
		logic id_we;
		logic st_we;
		logic rd_en;
	} mem_ctl_t;

endpackage
`default_nettype wire

>>> rtl/pending_command_ring_log.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pending_command_ring_log: ring of command slots with newest-first lookup
// An add or a clear word has its result registered in the cycle after accept.
// A set-status word walks at most the fill count of slots, newest first,
// one slot per cycle through the slot stores' registered read ports and
// one shared comparator. On an empty ring a set-status word is answered
// like an add, without a walk.
// Throughput: one add or clear word per cycle while results are taken.
// Reset clears the write pointer, fill count and handshake state; slot
// contents are not cleared and are only read once written.
// ----------------------------------------------------------------------------
module pending_command_ring_log #(
	parameter int DEPTH = pcrl_pkg::DEPTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [pcrl_pkg::OP_W-1:0]   opcode,
	input  wire logic [pcrl_pkg::ID_W-1:0]   cmd_id,
	input  wire logic [pcrl_pkg::ST_W-1:0]   new_status,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic                             found,
	output logic [pcrl_pkg::SLOT_W-1:0]      slot
);

	import pcrl_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	mem_ctl_t          mem_ctl;
	logic [PTR_W-1:0]  wr_addr;
	logic [ID_W-1:0]   wr_id;
	logic [ST_W-1:0]   wr_st;
	logic [PTR_W-1:0]  rd_addr;
	logic [ID_W-1:0]   rd_id;
	logic [ST_W-1:0]   rd_st;

	// The sequencer owns the write pointer, the fill count, the output
	// register and the newest-first walk.
	pcrl_seq #(
		.DEPTH(DEPTH)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.cmd_id     (cmd_id),
		.new_status (new_status),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.found      (found),
		.slot       (slot),
		.mem_ctl    (mem_ctl),
		.wr_addr    (wr_addr),
		.wr_id      (wr_id),
		.wr_st      (wr_st),
		.rd_addr    (rd_addr),
		.rd_id      (rd_id),
		.rd_st      (rd_st)
	);

	// Command ids are written only by adds; a status update rewrites just the
	// status store, so the two live in separate memories.
	pcrl_ram #(
		.DEPTH(DEPTH),
		.WIDTH(ID_W)
	) u_id_ram (
		.clk   (clk),
		.we    (mem_ctl.id_we),
		.waddr (wr_addr),
		.wdata (wr_id),
		.re    (mem_ctl.rd_en),
		.raddr (rd_addr),
		.rdata (rd_id)
	);

	pcrl_ram #(
		.DEPTH(DEPTH),
		.WIDTH(ST_W)
	) u_st_ram (
		.clk   (clk),
		.we    (mem_ctl.st_we),
		.waddr (wr_addr),
		.wdata (wr_st),
		.re    (mem_ctl.rd_en),
		.raddr (rd_addr),
		.rdata (rd_st)
	);

endmodule
`default_nettype wire

>>> rtl/pcrl_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcrl_ram: slot store
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module pcrl_ram #(
	parameter int DEPTH = pcrl_pkg::DEPTH_DEF,
	parameter int WIDTH = pcrl_pkg::ID_W,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

>>> rtl/pcrl_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcrl_seq: ring pointer, fill count and newest-first search sequencer
// Handles adds and clear straight from idle and walks the filled slots one per
// cycle through a single shared id/status comparator for a status update.
// ----------------------------------------------------------------------------
module pcrl_seq #(
	parameter int DEPTH = pcrl_pkg::DEPTH_DEF,
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [pcrl_pkg::OP_W-1:0]   opcode,
	input  wire logic [pcrl_pkg::ID_W-1:0]   cmd_id,
	input  wire logic [pcrl_pkg::ST_W-1:0]   new_status,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic                             found,
	output logic [pcrl_pkg::SLOT_W-1:0]      slot,
	output pcrl_pkg::mem_ctl_t               mem_ctl,
	output logic [PTR_W-1:0]                 wr_addr,
	output logic [pcrl_pkg::ID_W-1:0]        wr_id,
	output logic [pcrl_pkg::ST_W-1:0]        wr_st,
	output logic [PTR_W-1:0]                 rd_addr,
	input  wire logic [pcrl_pkg::ID_W-1:0]   rd_id,
	input  wire logic [pcrl_pkg::ST_W-1:0]   rd_st
);

	import pcrl_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_DONE
	} state_t;

	state_t            state_q;
	logic [PTR_W-1:0]  wp_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [PTR_W-1:0]  addr_q;
	logic [CNT_W-1:0]  rem_q;
	logic [ID_W-1:0]   key_q;
	logic [ST_W-1:0]   st_q;
	logic              vld_s1;
	logic              last_s1;
	logic [PTR_W-1:0]  idx_s1;
	logic              res_found_q;
	logic [SLOT_W-1:0] res_slot_q;

	logic accept;
	logic is_add;
	logic hit;
	logic miss_end;
	logic issue;
	logic res_load;

	function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
		return (p == '0) ? PTR_W'(DEPTH - 1) : p - PTR_W'(1);
	endfunction

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign in_ready = (state_q == S_IDLE) && (!out_valid || out_ready);
	assign accept   = in_valid && in_ready;
	assign is_add   = (opcode == OP_PLAIN_ADD) || (opcode == OP_CMD_ADD);

	// The shared comparator looks at the slot read in the previous cycle.
	assign hit      = vld_s1 && (rd_id == key_q) && (rd_st == ST_PENDING);
	assign miss_end = vld_s1 && !hit && last_s1;
	assign issue    = (state_q == S_SEARCH) && (rem_q != '0) && !hit && !miss_end;

	// A new result word is loaded into the output register this cycle.
	assign res_load = (accept && ((opcode != OP_SET_STATUS) || (cnt_q == '0))) ||
		((state_q == S_DONE) && (!out_valid || out_ready));

	assign rd_addr = addr_q;

	always_comb begin
		mem_ctl.id_we = accept && is_add;
		mem_ctl.st_we = (accept && is_add) || ((state_q == S_SEARCH) && hit);
		mem_ctl.rd_en = issue;
		if (state_q == S_SEARCH) begin
			wr_addr = idx_s1;
			wr_st   = st_q;
		end else begin
			wr_addr = wp_q;
			wr_st   = (opcode == OP_CMD_ADD) ? ST_PENDING : ST_NONE;
		end
		wr_id = (opcode == OP_CMD_ADD) ? cmd_id : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wp_q        <= '0;
			cnt_q       <= '0;
			addr_q      <= '0;
			rem_q       <= '0;
			key_q       <= '0;
			st_q        <= '0;
			vld_s1      <= 1'b0;
			last_s1     <= 1'b0;
			idx_s1      <= '0;
			res_found_q <= 1'b0;
			res_slot_q  <= '0;
			out_valid   <= 1'b0;
			found       <= 1'b0;
			slot        <= '0;
		end else begin
			vld_s1  <= issue;
			idx_s1  <= addr_q;
			last_s1 <= (rem_q == CNT_W'(1));
			if (out_valid && out_ready && !res_load) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (opcode)
							OP_PLAIN_ADD, OP_CMD_ADD: begin
								wp_q <= ptr_next(wp_q);
								if (cnt_q != CNT_W'(DEPTH)) begin
									cnt_q <= cnt_q + CNT_W'(1);
								end
								out_valid <= 1'b1;
								found     <= 1'b0;
								slot      <= '0;
							end
							OP_SET_STATUS: begin
								if (cnt_q == '0) begin
									out_valid <= 1'b1;
									found     <= 1'b0;
									slot      <= '0;
								end else begin
									key_q   <= cmd_id;
									st_q    <= new_status;
									addr_q  <= ptr_prev(wp_q);
									rem_q   <= cnt_q;
									state_q <= S_SEARCH;
								end
							end
							default: begin
								wp_q      <= '0;
								cnt_q     <= '0;
								out_valid <= 1'b1;
								found     <= 1'b0;
								slot      <= '0;
							end
						endcase
					end
				end
				S_SEARCH: begin
					if (issue) begin
						addr_q <= ptr_prev(addr_q);
						rem_q  <= rem_q - CNT_W'(1);
					end
					if (hit) begin
						res_found_q <= 1'b1;
						res_slot_q  <= SLOT_W'(idx_s1);
						state_q     <= S_DONE;
					end else if (miss_end) begin
						res_found_q <= 1'b0;
						res_slot_q  <= '0;
						state_q     <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						found     <= res_found_q;
						slot      <= res_slot_q;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

>>> tb/pcrl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcrl_checker: result predictor and scoreboard for the pending command ring
// Mirrors the ring on every accepted input word and checks each result word
// in order against the oldest predicted lookup answer.
// ----------------------------------------------------------------------------
module pcrl_checker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	input  wire logic                        in_ready,
	input  wire logic [pcrl_pkg::OP_W-1:0]   opcode,
	input  wire logic [pcrl_pkg::ID_W-1:0]   cmd_id,
	input  wire logic [pcrl_pkg::ST_W-1:0]   new_status,
	input  wire logic                        out_valid,
	input  wire logic                        out_ready,
	input  wire logic                        found,
	input  wire logic [pcrl_pkg::SLOT_W-1:0] slot,
	output int                               err_count,
	output int                               answers_owed,
	output int                               hits_seen
);
	import pcrl_pkg::*;

	localparam int RING  = DEPTH_DEF;
	localparam int IDX_W = $clog2(RING);

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] where;
	} lookup_answer_t;

	logic [ID_W-1:0] ring_id [RING];
	logic [ST_W-1:0] ring_st [RING];
	int unsigned     head;
	int unsigned     filled;
	lookup_answer_t  answer_q [$];

	task automatic store_slot(input logic [ID_W-1:0] id, input logic [ST_W-1:0] st);
		ring_id[head[IDX_W-1:0]] = id;
		ring_st[head[IDX_W-1:0]] = st;
		head = (head == RING - 1) ? 0 : head + 1;
		if (filled < RING)
			filled++;
	endtask

	task automatic apply_word(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
			input logic [ST_W-1:0] st, output lookup_answer_t ans);
		int unsigned idx;
		ans = '0;
		case (op)
			OP_PLAIN_ADD: store_slot('0, ST_NONE);
			OP_CMD_ADD: store_slot(id, ST_PENDING);
			OP_SET_STATUS: begin
				// Walk the filled slots from the newest one backwards.
				idx = head;
				for (int unsigned i = 0; i < filled && !ans.hit; i++) begin
					idx = (idx == 0) ? RING - 1 : idx - 1;
					if (ring_id[idx[IDX_W-1:0]] == id &&
							ring_st[idx[IDX_W-1:0]] == ST_PENDING) begin
						ring_st[idx[IDX_W-1:0]] = st;
						ans.hit = 1'b1;
						ans.where = idx[SLOT_W-1:0];
					end
				end
			end
			default: begin
				head = 0;
				filled = 0;
			end
		endcase
	endtask

	task automatic report_mismatch(input string what, input lookup_answer_t want);
		err_count++;
		if (err_count <= 10)
			$display("%0t mismatch (%s): expected found=%0b slot=%0d, got found=%0b slot=%0d",
				$realtime, what, want.hit, want.where, found, slot);
	endtask

	always @(posedge clk or negedge arst_n) begin
		lookup_answer_t ans;
		if (!arst_n) begin
			head = 0;
			filled = 0;
			err_count = 0;
			hits_seen = 0;
			answer_q.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (answer_q.size() == 0) begin
					report_mismatch("no result owed", '0);
				end else begin
					ans = answer_q.pop_front();
					if (found !== ans.hit || slot !== ans.where)
						report_mismatch("wrong field", ans);
					else if (ans.hit)
						hits_seen++;
				end
			end
			if (in_valid && in_ready) begin
				apply_word(opcode, cmd_id, new_status, ans);
				answer_q.push_back(ans);
			end
		end
		answers_owed = answer_q.size();
	end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the pending command ring log
// Drives directed and random command words through three idling mixes and
// one long receiver hold-off; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module testbench;
	import pcrl_pkg::*;

	// A word with no acceptance on either channel for this many cycles means
	// the block has hung. The slowest legal gap is a full-ring lookup plus the
	// long receiver hold-off, both far below this.
	localparam int STALL_LIMIT  = 4000;
	localparam int HOLD_CYCLES  = 300;
	localparam int PHASE_WORDS  = 550;
	localparam int ID_POOL_SIZE = 8;
	localparam int POOL_IDX_W   = $clog2(ID_POOL_SIZE);

	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              in_valid   = 1'b0;
	logic [OP_W-1:0]   opcode     = OP_PLAIN_ADD;
	logic [ID_W-1:0]   cmd_id     = '0;
	logic [ST_W-1:0]   new_status = ST_NONE;
	logic              out_ready  = 1'b0;
	logic              in_ready;
	logic              out_valid;
	logic              found;
	logic [SLOT_W-1:0] slot;

	int err_count;
	int answers_owed;
	int hits_seen;

	// Idling mix, shared by the sender (main process) and the receiver.
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_asks   = 0;
	int hold_served = 0;
	int hold_left   = 0;

	int words_sent   = 0;
	int lookups_sent = 0;
	int clears_sent  = 0;
	int quiet_cycles = 0;

	logic [ID_W-1:0] id_pool [ID_POOL_SIZE];

	pending_command_ring_log u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.cmd_id     (cmd_id),
		.new_status (new_status),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.found      (found),
		.slot       (slot)
	);

	pcrl_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.cmd_id       (cmd_id),
		.new_status   (new_status),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.found        (found),
		.slot         (slot),
		.err_count    (err_count),
		.answers_owed (answers_owed),
		.hits_seen    (hits_seen)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// The receiver decides its ready at each falling edge. A hold-off request
	// from the main process keeps ready low for a long counted stretch, so the
	// block backs up and has to drop its input ready.
	always @(negedge clk) begin
		if (hold_asks != hold_served) begin
			hold_served = hold_asks;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Watchdog: counts cycles in which neither channel moves a word.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", STALL_LIMIT);
			$display("FAIL pending_command_ring_log");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offers one word from a falling edge and returns at the falling edge
	// after it has been taken. Random gaps come before the word, and valid is
	// only ever assigned once per edge.
	task automatic send_word(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
			input logic [ST_W-1:0] st);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		opcode     <= op;
		cmd_id     <= id;
		new_status <= st;
		do
			@(posedge clk);
		while (!in_ready);
		words_sent++;
		if (op == OP_SET_STATUS)
			lookups_sent++;
		if (op == OP_CLEAR)
			clears_sent++;
		@(negedge clk);
	endtask

	// Random traffic is mostly adds and lookups on a small pool of ids, so that
	// lookups hit, duplicates stack up and the ring wraps. Clears only fall in
	// the last part of every 200-word window, which lets the ring fill first.
	task automatic random_word(input int index);
		int              pick;
		logic [OP_W-1:0] op;
		logic [ID_W-1:0] id;
		logic [ST_W-1:0] st;
		pick = $urandom_range(99);
		if (pick < 20)
			op = OP_PLAIN_ADD;
		else if (pick < 55)
			op = OP_CMD_ADD;
		else if (pick < 96 || (index % 200) < 120)
			op = OP_SET_STATUS;
		else
			op = OP_CLEAR;

		pick = $urandom_range(99);
		if (pick < 80)
			id = id_pool[POOL_IDX_W'($urandom_range(ID_POOL_SIZE - 1))];
		else if (pick < 92)
			id = $urandom;
		else if (pick < 96)
			id = '0;
		else
			id = '1;

		// Rewriting the status as pending keeps the slot searchable.
		pick = $urandom_range(99);
		if (pick < 15)
			st = ST_PENDING;
		else
			st = ST_W'($urandom_range(15));
		send_word(op, id, st);
	endtask

	initial begin
		for (int k = 0; k < ID_POOL_SIZE; k++)
			id_pool[POOL_IDX_W'(k)] = $urandom;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		tx_idle_pct = 13;
		rx_idle_pct = 48;

		// Directed opening. A lookup on the empty ring misses; then the ring
		// gets a plain entry, the two extreme ids and a duplicated pending id.
		send_word(OP_SET_STATUS, 32'h0000_0000, 4'hF);
		send_word(OP_PLAIN_ADD,  32'hFFFF_FFFF, 4'hF);
		send_word(OP_CMD_ADD,    32'h0000_0000, 4'hF);
		send_word(OP_CMD_ADD,    32'hFFFF_FFFF, 4'h0);
		send_word(OP_CMD_ADD,    32'h0000_1234, 4'h5);
		send_word(OP_CMD_ADD,    32'h0000_1234, 4'hA);
		// Only the newest of the two matching pending slots is updated; the
		// older one is taken next, and rewriting it as pending keeps it live.
		send_word(OP_SET_STATUS, 32'h0000_1234, 4'hF);
		send_word(OP_SET_STATUS, 32'h0000_1234, ST_PENDING);
		send_word(OP_SET_STATUS, 32'h0000_1234, ST_NONE);
		send_word(OP_SET_STATUS, 32'h0000_1234, 4'h3);
		// Id zero matches the command slot, never the plain slot of status none.
		send_word(OP_SET_STATUS, 32'h0000_0000, 4'h7);
		send_word(OP_SET_STATUS, 32'h0000_0000, 4'h2);
		send_word(OP_SET_STATUS, 32'hFFFF_FFFF, ST_NONE);
		send_word(OP_SET_STATUS, 32'hDEAD_BEEF, 4'h8);
		// A cleared slot keeps its contents but is no longer searched.
		send_word(OP_CMD_ADD,    32'hA5A5_A5A5, 4'h0);
		send_word(OP_CLEAR,      32'h5A5A_5A5A, 4'hF);
		send_word(OP_SET_STATUS, 32'hA5A5_A5A5, 4'h9);
		send_word(OP_CMD_ADD,    32'hA5A5_A5A5, 4'h0);
		send_word(OP_SET_STATUS, 32'hA5A5_A5A5, 4'h9);
		send_word(OP_CLEAR,      32'h0000_0000, 4'h0);
		send_word(OP_CLEAR,      32'hFFFF_FFFF, 4'hF);
		send_word(OP_PLAIN_ADD,  32'h8000_0001, 4'h1);
		send_word(OP_SET_STATUS, 32'h0000_0000, 4'h1);

		for (int n = 0; n < PHASE_WORDS; n++)
			random_word(n);

		tx_idle_pct = 48;
		rx_idle_pct = 13;
		for (int n = 0; n < PHASE_WORDS; n++)
			random_word(n);

		// Last mix: no idling at all, opened by the long receiver hold-off
		// while the sender keeps offering words.
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_asks++;
		for (int n = 0; n < PHASE_WORDS; n++)
			random_word(n);
		in_valid <= 1'b0;

		while (answers_owed != 0)
			@(negedge clk);
		repeat (DEPTH_DEF + 8) @(negedge clk);

		$display("Covered %0d words: %0d status lookups with %0d hits and %0d clears,",
			words_sent, lookups_sent, hits_seen, clears_sent);
		$display("over three idling mixes and one long output hold-off; %0d mismatches.",
			err_count);
		if (err_count == 0 && answers_owed == 0) begin
			$display("PASS pending_command_ring_log");
		end else begin
			$display("FAIL pending_command_ring_log");
		end
		$finish;
	end

endmodule
